// ===== rtl/core/cch_pkg.sv =====
package cch_pkg;

  localparam int MAX_SAMPLES  = 256;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_LIMIT   = 24;
  localparam int NSTEPS       = (CORDIC_STEPS > STEP_LIMIT) ? STEP_LIMIT : CORDIC_STEPS;
  localparam int STEP_W       = 5;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 20;

  localparam int CW     = 58;   // CORDIC x/y datapath width
  localparam int AW     = 34;   // CORDIC angle register width
  localparam int DIV_W  = 34;   // divider magnitude width
  localparam int DIVQ_W = 35;   // signed dividend / quotient width
  localparam int DIVC_W = 6;

  localparam longint CAL_MAX    = 64'sd16777215;
  localparam longint CAL_MIN    = -64'sd16777216;
  localparam int     UNIT_START = 19898;
  localparam int     UNIT_MAX   = 32767;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_OFFSET_X = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_OFFSET_Y = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_GAIN_X   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_GAIN_Y   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_CROSS_XY = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_CROSS_YX = 3'd5;

  // CORDIC jobs
  localparam logic [2:0] JOB_RAW_VEC  = 3'd0;
  localparam logic [2:0] JOB_RAW_ROT  = 3'd1;
  localparam logic [2:0] JOB_CAL_VEC  = 3'd2;
  localparam logic [2:0] JOB_CAL_ROT  = 3'd3;
  localparam logic [2:0] JOB_HEAD_RAW = 3'd4;
  localparam logic [2:0] JOB_HEAD_CAL = 3'd5;

  // divider jobs
  localparam logic [2:0] DIV_RAW_X = 3'd0;
  localparam logic [2:0] DIV_RAW_Y = 3'd1;
  localparam logic [2:0] DIV_RAW_Z = 3'd2;
  localparam logic [2:0] DIV_CAL_X = 3'd3;
  localparam logic [2:0] DIV_CAL_Y = 3'd4;
  localparam logic [2:0] DIV_MAG   = 3'd5;

  localparam logic [2:0] MUL_LAST = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEC, ST_MUL, ST_CORD, ST_CORW, ST_MAGW, ST_DIV, ST_DIVW, ST_EMIT
  } cch_state_t;

  typedef struct packed {
    logic       capture;
    logic       drop;
    logic       mul;
    logic       sqrt_start;
    logic       cord_start;
    logic       cord_store;
    logic       div_start;
    logic       div_store;
    logic       commit;
    logic       emit;
    logic [2:0] idx;
  } cch_cmd_t;

  typedef struct packed {
    logic opcode;
    logic full;
    logic empty;
    logic cord_busy;
    logic div_busy;
    logic sqrt_busy;
  } cch_stat_t;

  function automatic logic [31:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/cch_cordic.sv =====
module cch_cordic import cch_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 rot,
  input  logic signed [24:0]   x_in,
  input  logic signed [24:0]   y_in,
  input  logic [31:0]          ang_in,
  output logic                 busy,
  output logic [31:0]          ang_out,
  output logic signed [15:0]   cos_out,
  output logic signed [15:0]   sin_out
);

  logic                  busy_r, rot_r, zero_r;
  logic [STEP_W-1:0]     i_r;
  logic signed [CW-1:0]  x_r, y_r;
  logic signed [AW-1:0]  z_r;
  logic signed [CW-1:0]  xs, ys, dx, dy;
  logic [31:0]           a_fix;
  logic                  flip;
  logic signed [AW-1:0]  at;

  function automatic logic signed [15:0] clamp_unit(input logic signed [CW-1:0] v);
    logic signed [15:0] r;
    if (v > CW'(UNIT_MAX)) r = 16'(UNIT_MAX);
    else if (v < -CW'(UNIT_MAX)) r = -16'(UNIT_MAX);
    else r = v[15:0];
    return r;
  endfunction

  assign xs    = CW'(x_in) <<< 30;
  assign ys    = CW'(y_in) <<< 30;
  assign flip  = (ang_in[31:30] == 2'd1) || (ang_in[31:30] == 2'd2);
  assign a_fix = ang_in + (flip ? 32'h80000000 : 32'h0);
  assign dx    = y_r >>> i_r;
  assign dy    = x_r >>> i_r;
  assign at    = AW'(atan_lut(i_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (i_r == STEP_W'(NSTEPS - 1))) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      i_r    <= '0;
      rot_r  <= rot;
      zero_r <= (x_in == '0) && (y_in == '0);
      if (rot) begin
        x_r <= flip ? -CW'(UNIT_START) : CW'(UNIT_START);
        y_r <= '0;
        z_r <= AW'($signed(a_fix));
      end else if (x_in < 0) begin
        x_r <= -xs;
        y_r <= -ys;
        z_r <= AW'(34'h0_8000_0000);
      end else begin
        x_r <= xs;
        y_r <= ys;
        z_r <= '0;
      end
    end else if (busy_r) begin
      i_r <= i_r + 1'b1;
      if (rot_r) begin
        if (!z_r[AW-1]) begin
          x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + at;
        end
      end else begin
        if (y_r > 0) begin
          x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + at;
        end else begin
          x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - at;
        end
      end
    end
  end

  assign busy    = busy_r;
  assign ang_out = zero_r ? 32'h0 : z_r[31:0];
  assign cos_out = clamp_unit(x_r);
  assign sin_out = clamp_unit(y_r);

endmodule

// ===== rtl/core/cch_div.sv =====
module cch_div import cch_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIVQ_W-1:0] dividend,
  input  logic [8:0]               divisor,
  output logic                     busy,
  output logic signed [DIVQ_W-1:0] quotient
);

  logic              busy_r, neg_r;
  logic [DIVC_W-1:0] cnt_r;
  logic [DIV_W-1:0]  num_r;
  logic [8:0]        den_r;
  logic [9:0]        rem_r, rem_sh;
  logic [DIVQ_W-1:0] mag;
  logic              ge;

  assign mag    = dividend[DIVQ_W-1] ? DIVQ_W'(-dividend) : DIVQ_W'(dividend);
  assign rem_sh = {rem_r[8:0], num_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (cnt_r == DIVC_W'(DIV_W - 1))) begin
      busy_r <= 1'b0;
    end
  end

  // restoring division, quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      neg_r <= dividend[DIVQ_W-1];
      num_r <= mag[DIV_W-1:0];
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      num_r <= {num_r[DIV_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? -$signed(DIVQ_W'(num_r)) : $signed(DIVQ_W'(num_r));

endmodule

// ===== rtl/core/cch_datapath.sv =====
module cch_datapath import cch_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cch_cmd_t            cmd,
  output cch_stat_t           stat,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data,
  input  logic                in_opcode,
  input  logic signed [15:0]  in_sample_x,
  input  logic signed [15:0]  in_sample_y,
  input  logic signed [15:0]  in_sample_z,
  output logic signed [15:0]  out_mean_raw_x,
  output logic signed [15:0]  out_mean_raw_y,
  output logic signed [15:0]  out_mean_raw_z,
  output logic signed [24:0]  out_mean_cal_x,
  output logic signed [24:0]  out_mean_cal_y,
  output logic [15:0]         out_heading_raw,
  output logic [15:0]         out_heading_cal,
  output logic [24:0]         out_mean_magnitude,
  output logic [8:0]          out_samples_taken,
  output logic                out_no_samples,
  output logic                out_overflow_seen
);

  logic signed [19:0] offx_r, offy_r;
  logic signed [15:0] gx_r, gy_r, cxy_r, cyx_r;

  logic               op_r;
  logic signed [15:0] rx_r, ry_r, rz_r;
  logic signed [21:0] x0_r, y0_r;
  logic signed [24:0] xc_r, yc_r;
  logic [31:0]        ang_r;

  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod_r;
  logic signed [51:0] acc_r, cal_sum, cal_sh, sq_sum;
  logic signed [24:0] cal_sat;

  logic [49:0]        sq_v_r, sq_bit_r;
  logic [50:0]        sq_root_r, sq_trial;

  logic signed [24:0] sum_raw_x_r, sum_raw_y_r, sum_raw_z_r;
  logic signed [33:0] sum_cal_x_r, sum_cal_y_r;
  logic [33:0]        sum_mag_r;
  logic signed [24:0] sum_sin_raw_r, sum_cos_raw_r, sum_sin_cal_r, sum_cos_cal_r;
  logic [8:0]         count_r;
  logic               dropped_r;

  logic signed [15:0] res_raw_x_r, res_raw_y_r, res_raw_z_r;
  logic signed [24:0] res_cal_x_r, res_cal_y_r;
  logic [24:0]        res_mag_r;
  logic [15:0]        res_head_raw_r, res_head_cal_r;

  logic               cord_busy, cord_rot;
  logic signed [24:0] cord_x, cord_y;
  logic [31:0]        cord_ang, head_rnd;
  logic signed [15:0] cord_cos, cord_sin;

  logic                     div_busy;
  logic signed [DIVQ_W-1:0] div_num, div_q;
  logic                     empty;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offx_r <= -20'sd440;
      offy_r <= -20'sd8808;
      gx_r   <= 16'sd4768;
      gy_r   <= 16'sd3588;
      cxy_r  <= 16'sd205;
      cyx_r  <= 16'sd205;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_X: offx_r <= cfg_data;
        CFG_OFFSET_Y: offy_r <= cfg_data;
        CFG_GAIN_X:   gx_r   <= cfg_data[15:0];
        CFG_GAIN_Y:   gy_r   <= cfg_data[15:0];
        CFG_CROSS_XY: cxy_r  <= cfg_data[15:0];
        CFG_CROSS_YX: cyx_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // capture, remove hard-iron offset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_opcode;
      rx_r <= in_sample_x;
      ry_r <= in_sample_y;
      rz_r <= in_sample_z;
      x0_r <= {{2{in_sample_x[15]}}, in_sample_x, 4'b0} - {{2{offx_r[19]}}, offx_r};
      y0_r <= {{2{in_sample_y[15]}}, in_sample_y, 4'b0} - {{2{offy_r[19]}}, offy_r};
    end
  end

  // shared multiplier: soft-iron matrix, then the two squares
  always_comb begin
    case (cmd.idx)
      3'd0:    begin mul_a = 25'(gx_r);  mul_b = 25'(x0_r); end
      3'd1:    begin mul_a = 25'(cxy_r); mul_b = 25'(y0_r); end
      3'd2:    begin mul_a = 25'(cyx_r); mul_b = 25'(x0_r); end
      3'd3:    begin mul_a = 25'(gy_r);  mul_b = 25'(y0_r); end
      3'd5:    begin mul_a = xc_r;       mul_b = xc_r;      end
      3'd6:    begin mul_a = yc_r;       mul_b = yc_r;      end
      default: begin mul_a = '0;         mul_b = '0;        end
    endcase
  end

  assign cal_sum = acc_r + 52'(prod_r) + 52'sd2048;
  assign cal_sh  = cal_sum >>> 12;
  assign sq_sum  = acc_r + 52'(prod_r);

  always_comb begin
    if (cal_sh > CAL_MAX) cal_sat = 25'(CAL_MAX);
    else if (cal_sh < CAL_MIN) cal_sat = 25'(CAL_MIN);
    else cal_sat = cal_sh[24:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= mul_a * mul_b;
      if ((cmd.idx == 3'd1) || (cmd.idx == 3'd3) || (cmd.idx == 3'd6)) acc_r <= 52'(prod_r);
      if (cmd.idx == 3'd2) xc_r <= cal_sat;
      if (cmd.idx == 3'd4) yc_r <= cal_sat;
    end
  end

  // integer square root, one result bit per cycle
  assign sq_trial = sq_root_r + 51'(sq_bit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_bit_r <= '0;
    end else if (cmd.sqrt_start) begin
      sq_bit_r <= 50'd1 << 48;
    end else if (sq_bit_r != '0) begin
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_v_r    <= sq_sum[49:0];
      sq_root_r <= '0;
    end else if (sq_bit_r != '0) begin
      if (51'(sq_v_r) >= sq_trial) begin
        sq_v_r    <= sq_v_r - sq_trial[49:0];
        sq_root_r <= (sq_root_r >> 1) + 51'(sq_bit_r);
      end else begin
        sq_root_r <= sq_root_r >> 1;
      end
    end
  end

  // CORDIC job select
  always_comb begin
    cord_rot = (cmd.idx == JOB_RAW_ROT) || (cmd.idx == JOB_CAL_ROT);
    case (cmd.idx)
      JOB_RAW_VEC:  begin cord_x = 25'(rx_r);     cord_y = 25'(ry_r);     end
      JOB_CAL_VEC:  begin cord_x = xc_r;          cord_y = yc_r;          end
      JOB_HEAD_RAW: begin cord_x = sum_cos_raw_r; cord_y = sum_sin_raw_r; end
      JOB_HEAD_CAL: begin cord_x = sum_cos_cal_r; cord_y = sum_sin_cal_r; end
      default:      begin cord_x = '0;            cord_y = '0;            end
    endcase
  end

  cch_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.cord_start),
    .rot     (cord_rot),
    .x_in    (cord_x),
    .y_in    (cord_y),
    .ang_in  (ang_r),
    .busy    (cord_busy),
    .ang_out (cord_ang),
    .cos_out (cord_cos),
    .sin_out (cord_sin)
  );

  assign head_rnd = cord_ang + 32'h8000;

  always_comb begin
    case (cmd.idx)
      DIV_RAW_X: div_num = DIVQ_W'(sum_raw_x_r);
      DIV_RAW_Y: div_num = DIVQ_W'(sum_raw_y_r);
      DIV_RAW_Z: div_num = DIVQ_W'(sum_raw_z_r);
      DIV_CAL_X: div_num = DIVQ_W'(sum_cal_x_r);
      DIV_CAL_Y: div_num = DIVQ_W'(sum_cal_y_r);
      default:   div_num = $signed({1'b0, sum_mag_r});
    endcase
  end

  cch_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.cord_store) begin
      case (cmd.idx)
        JOB_RAW_VEC, JOB_CAL_VEC: ang_r <= cord_ang;
        JOB_HEAD_RAW: res_head_raw_r <= head_rnd[31:16];
        JOB_HEAD_CAL: res_head_cal_r <= head_rnd[31:16];
        default: ;
      endcase
    end
    if (cmd.div_store) begin
      case (cmd.idx)
        DIV_RAW_X: res_raw_x_r <= div_q[15:0];
        DIV_RAW_Y: res_raw_y_r <= div_q[15:0];
        DIV_RAW_Z: res_raw_z_r <= div_q[15:0];
        DIV_CAL_X: res_cal_x_r <= div_q[24:0];
        DIV_CAL_Y: res_cal_y_r <= div_q[24:0];
        default:   res_mag_r   <= div_q[24:0];
      endcase
    end
  end

  // window accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      sum_raw_x_r   <= '0;
      sum_raw_y_r   <= '0;
      sum_raw_z_r   <= '0;
      sum_cal_x_r   <= '0;
      sum_cal_y_r   <= '0;
      sum_mag_r     <= '0;
      sum_sin_raw_r <= '0;
      sum_cos_raw_r <= '0;
      sum_sin_cal_r <= '0;
      sum_cos_cal_r <= '0;
      count_r       <= '0;
      dropped_r     <= 1'b0;
    end else begin
      if (cmd.drop) dropped_r <= 1'b1;
      if (cmd.cord_store && (cmd.idx == JOB_RAW_ROT)) begin
        sum_cos_raw_r <= sum_cos_raw_r + 25'(cord_cos);
        sum_sin_raw_r <= sum_sin_raw_r + 25'(cord_sin);
      end
      if (cmd.cord_store && (cmd.idx == JOB_CAL_ROT)) begin
        sum_cos_cal_r <= sum_cos_cal_r + 25'(cord_cos);
        sum_sin_cal_r <= sum_sin_cal_r + 25'(cord_sin);
      end
      if (cmd.commit) begin
        sum_raw_x_r <= sum_raw_x_r + 25'(rx_r);
        sum_raw_y_r <= sum_raw_y_r + 25'(ry_r);
        sum_raw_z_r <= sum_raw_z_r + 25'(rz_r);
        sum_cal_x_r <= sum_cal_x_r + 34'(xc_r);
        sum_cal_y_r <= sum_cal_y_r + 34'(yc_r);
        sum_mag_r   <= sum_mag_r + 34'(sq_root_r[24:0]);
        count_r     <= count_r + 1'b1;
      end
    end
  end

  assign empty = (count_r == '0);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_mean_raw_x     <= empty ? '0 : res_raw_x_r;
      out_mean_raw_y     <= empty ? '0 : res_raw_y_r;
      out_mean_raw_z     <= empty ? '0 : res_raw_z_r;
      out_mean_cal_x     <= empty ? '0 : res_cal_x_r;
      out_mean_cal_y     <= empty ? '0 : res_cal_y_r;
      out_heading_raw    <= empty ? '0 : res_head_raw_r;
      out_heading_cal    <= empty ? '0 : res_head_cal_r;
      out_mean_magnitude <= empty ? '0 : res_mag_r;
      out_samples_taken  <= count_r;
      out_no_samples     <= empty;
      out_overflow_seen  <= dropped_r;
    end
  end

  assign stat.opcode    = op_r;
  assign stat.full      = (count_r >= 9'(MAX_SAMPLES));
  assign stat.empty     = empty;
  assign stat.cord_busy = cord_busy;
  assign stat.div_busy  = div_busy;
  assign stat.sqrt_busy = (sq_bit_r != '0);

endmodule

// ===== rtl/core/cch_ctrl.sv =====
module cch_ctrl import cch_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  cch_stat_t stat,
  output cch_cmd_t  cmd
);

  cch_state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DEC;
        end
      end
      ST_DEC: begin
        cnt_nxt = '0;
        if (stat.opcode == OP_REPORT) begin
          state_nxt = stat.empty ? ST_EMIT : ST_DIV;
        end else if (stat.full) begin
          cmd.drop  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          cmd.sqrt_start = 1'b1;
          cnt_nxt        = JOB_RAW_VEC;
          state_nxt      = ST_CORD;
        end
      end
      ST_CORD: begin
        cmd.cord_start = 1'b1;
        state_nxt      = ST_CORW;
      end
      ST_CORW: begin
        if (!stat.cord_busy) begin
          cmd.cord_store = 1'b1;
          cnt_nxt        = cnt_r + 1'b1;
          if (cnt_r == JOB_CAL_ROT) state_nxt = ST_MAGW;
          else if (cnt_r == JOB_HEAD_CAL) state_nxt = ST_EMIT;
          else state_nxt = ST_CORD;
        end
      end
      ST_MAGW: begin
        if (!stat.sqrt_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (!stat.div_busy) begin
          cmd.div_store = 1'b1;
          if (cnt_r == DIV_MAG) begin
            cnt_nxt   = JOB_HEAD_RAW;
            state_nxt = ST_CORD;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/compass_calibrate_heading_average.sv =====
// Magnetometer calibration and heading averager. Sample items (opcode 0) remove the
// hard-iron offsets, apply the 2x2 soft-iron matrix (Q3.12), and add raw x/y/z, calibrated
// x/y (Q4), horizontal magnitude and the raw and calibrated unit heading vectors to a window;
// a sample that would take the window past 256 entries is dropped and flagged. A report
// item (opcode 1) returns the window means (truncated toward zero), the vector-averaged
// headings at 65536 units per turn, the count and the flags, then clears the window. Items
// are handled one at a time; in_stall stays high while one is in work, and the finished
// report waits in an output register so the next item can be taken meanwhile. A sample's
// work is four passes through the single iterative CORDIC unit (two vectoring, two
// rotation), with the square root running in parallel. A report's work is six passes
// through the bit-serial divider plus two CORDIC vectoring passes. Configuration writes are
// accepted at any time (cfg_ready is tied high) and should be issued only while the block is
// idle; indexes beyond the six registers are ignored.
module compass_calibrate_heading_average import cch_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_opcode,
  input  logic signed [15:0]  in_sample_x,
  input  logic signed [15:0]  in_sample_y,
  input  logic signed [15:0]  in_sample_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_mean_raw_x,
  output logic signed [15:0]  out_mean_raw_y,
  output logic signed [15:0]  out_mean_raw_z,
  output logic signed [24:0]  out_mean_cal_x,
  output logic signed [24:0]  out_mean_cal_y,
  output logic [15:0]         out_heading_raw,
  output logic [15:0]         out_heading_cal,
  output logic [24:0]         out_mean_magnitude,
  output logic [8:0]          out_samples_taken,
  output logic                out_no_samples,
  output logic                out_overflow_seen,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data
);

  cch_cmd_t  cmd;
  cch_stat_t stat;

  // configuration never back-pressures
  assign cfg_ready = 1'b1;

  // sequencer: accept, sample/report flow, output transfer
  cch_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic, accumulators, CORDIC, divider and result register
  cch_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_opcode          (in_opcode),
    .in_sample_x        (in_sample_x),
    .in_sample_y        (in_sample_y),
    .in_sample_z        (in_sample_z),
    .out_mean_raw_x     (out_mean_raw_x),
    .out_mean_raw_y     (out_mean_raw_y),
    .out_mean_raw_z     (out_mean_raw_z),
    .out_mean_cal_x     (out_mean_cal_x),
    .out_mean_cal_y     (out_mean_cal_y),
    .out_heading_raw    (out_heading_raw),
    .out_heading_cal    (out_heading_cal),
    .out_mean_magnitude (out_mean_magnitude),
    .out_samples_taken  (out_samples_taken),
    .out_no_samples     (out_no_samples),
    .out_overflow_seen  (out_overflow_seen)
  );

  // an empty-window report carries no count and no overflow
  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_samples |-> (out_samples_taken == '0) && !out_overflow_seen)
    else $error("empty report carries count or overflow");

  // never overwrite a result that is still waiting for its transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  // a captured item holds off the next one
  a_capture_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> in_stall)
    else $error("input taken while an item is in work");

  // a sample is only committed into a window that has room
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !stat.full && !stat.sqrt_busy)
    else $error("sample committed into a full window");

endmodule
